// ===== hw/rtl/kvt_pkg.sv =====
`timescale 1ns / 1ps

package kvt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_COND    = 3'd3,
        MODE_QUOTED  = 3'd4,
        MODE_QESC    = 3'd5,
        MODE_BARE    = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        EV_OPEN   = 3'd0,
        EV_CLOSE  = 3'd1,
        EV_BYTE   = 3'd2,
        EV_STREND = 3'd3,
        EV_END    = 3'd4
    } kind_t;

    localparam int unsigned MaxEvents = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

endpackage

// ===== hw/rtl/keyvalues_text_tokenizer.sv =====
`timescale 1ns / 1ps

// The first event of a transaction is presented in the cycle after the transaction is accepted.
// Throughput: one input transaction per cycle while each byte yields at most one event and
// the output is not stalled. A byte that yields k events (up to three) holds the input stalled
// until the last of them is being taken, since the event buffer drains one event per unstalled cycle.
// Reset (asynchronous, active low) returns the lexer to idle and empties the event buffer.
module keyvalues_text_tokenizer
    import kvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_kind,
    output logic [7:0] event_byte,
    output logic       last_of_run
);

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    kind_t       kind_reg [MaxEvents];
    logic [7:0]  byte_reg [MaxEvents];
    kind_t       kind_next [MaxEvents];
    logic [7:0]  byte_next [MaxEvents];

    logic        in_acc;
    logic        out_acc;

    logic        is_space;
    logic        ends_bare;
    logic        idle_push;
    kind_t       idle_kind;
    mode_t       idle_mode;
    logic [7:0]  esc_byte;

    assign out_valid   = (cnt_reg != 2'd0);
    assign in_stall    = (cnt_reg > 2'd1) || ((cnt_reg == 2'd1) && out_stall);
    assign in_acc      = in_valid && !in_stall;
    assign out_acc     = out_valid && !out_stall;
    assign event_kind  = kind_reg[0];
    assign event_byte  = byte_reg[0];
    assign last_of_run = (cnt_reg == 2'd1);

    assign is_space  = text_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    assign ends_bare = is_space || (text_byte inside {CH_LBRACE, CH_RBRACE, CH_QUOTE});
    assign esc_byte  = (text_byte == CH_LOW_N) ? CH_LF :
                       (text_byte == CH_LOW_T) ? CH_TAB : text_byte;

    // Handling of a byte that arrives between tokens.
    always_comb
    begin
        idle_push = 1'b0;
        idle_kind = EV_BYTE;
        idle_mode = MODE_IDLE;
        if (is_space)
        begin
            idle_mode = MODE_IDLE;
        end
        else if (text_byte == CH_SLASH)
        begin
            idle_mode = MODE_SLASH;
        end
        else if (text_byte == CH_LBRACK)
        begin
            idle_mode = MODE_COND;
        end
        else if (text_byte == CH_LBRACE)
        begin
            idle_push = 1'b1;
            idle_kind = EV_OPEN;
        end
        else if (text_byte == CH_RBRACE)
        begin
            idle_push = 1'b1;
            idle_kind = EV_CLOSE;
        end
        else if (text_byte == CH_QUOTE)
        begin
            idle_mode = MODE_QUOTED;
        end
        else
        begin
            idle_push = 1'b1;
            idle_kind = EV_BYTE;
            idle_mode = MODE_BARE;
        end
    end

    // Event generation: events are appended in order, up to three per transaction.
    always_comb
    begin
        cnt_next  = 2'd0;
        mode_next = mode_reg;
        for (int i = 0; i < MaxEvents; i++)
        begin
            kind_next[i] = EV_OPEN;
            byte_next[i] = 8'h00;
        end

        if (end_of_text)
        begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    kind_next[0] = EV_BYTE;
                    byte_next[0] = CH_SLASH;
                    kind_next[1] = EV_STREND;
                    cnt_next     = 2'd2;
                end
                MODE_QESC:
                begin
                    kind_next[0] = EV_BYTE;
                    byte_next[0] = CH_BSLASH;
                    kind_next[1] = EV_STREND;
                    cnt_next     = 2'd2;
                end
                MODE_QUOTED, MODE_BARE:
                begin
                    kind_next[0] = EV_STREND;
                    cnt_next     = 2'd1;
                end
                default:
                begin
                    cnt_next = 2'd0;
                end
            endcase
            kind_next[cnt_next] = EV_END;
            byte_next[cnt_next] = 8'h00;
            cnt_next            = cnt_next + 2'd1;
            mode_next           = MODE_IDLE;
        end
        else
        begin
            case (mode_reg)
                MODE_SLASH, MODE_BARE:
                begin
                    if ((mode_reg == MODE_SLASH) && (text_byte == CH_SLASH))
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        // A lone slash opens a bare string with the slash as its first byte.
                        if (mode_reg == MODE_SLASH)
                        begin
                            kind_next[0] = EV_BYTE;
                            byte_next[0] = CH_SLASH;
                            cnt_next     = 2'd1;
                        end
                        if (ends_bare)
                        begin
                            kind_next[cnt_next] = EV_STREND;
                            cnt_next            = cnt_next + 2'd1;
                            if (idle_push)
                            begin
                                kind_next[cnt_next] = idle_kind;
                                byte_next[cnt_next] = (idle_kind == EV_BYTE) ? text_byte : 8'h00;
                                cnt_next            = cnt_next + 2'd1;
                            end
                            mode_next = idle_mode;
                        end
                        else
                        begin
                            kind_next[cnt_next] = EV_BYTE;
                            byte_next[cnt_next] = text_byte;
                            cnt_next            = cnt_next + 2'd1;
                            mode_next           = MODE_BARE;
                        end
                    end
                end
                MODE_COMMENT:
                begin
                    if (text_byte == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_COND:
                begin
                    if (text_byte == CH_RBRACK)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_QUOTED:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        kind_next[0] = EV_STREND;
                        cnt_next     = 2'd1;
                        mode_next    = MODE_IDLE;
                    end
                    else if (text_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_QESC;
                    end
                    else
                    begin
                        kind_next[0] = EV_BYTE;
                        byte_next[0] = text_byte;
                        cnt_next     = 2'd1;
                    end
                end
                MODE_QESC:
                begin
                    kind_next[0] = EV_BYTE;
                    byte_next[0] = esc_byte;
                    cnt_next     = 2'd1;
                    mode_next    = MODE_QUOTED;
                end
                default:
                begin
                    if (idle_push)
                    begin
                        kind_next[0] = idle_kind;
                        byte_next[0] = (idle_kind == EV_BYTE) ? text_byte : 8'h00;
                        cnt_next     = 2'd1;
                    end
                    mode_next = idle_mode;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= 2'd0;
        end
        else if (in_acc)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
        else if (out_acc)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Event buffer: loaded on input, shifted toward slot zero as events are taken.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < MaxEvents; i++)
            begin
                kind_reg[i] <= kind_next[i];
                byte_reg[i] <= byte_next[i];
            end
        end
        else if (out_acc)
        begin
            for (int i = 0; i < MaxEvents - 1; i++)
            begin
                kind_reg[i] <= kind_reg[i + 1];
                byte_reg[i] <= byte_reg[i + 1];
            end
        end
    end

    a_eot_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && end_of_text |=> mode_reg == MODE_IDLE)
        else $error("lexer mode not idle after end of text");

    a_eot_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && end_of_text |=> out_valid)
        else $error("end of text produced no event");

    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> cnt_reg != 2'd0)
        else $error("input stalled with an empty event buffer");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_END) |-> last_of_run)
        else $error("end-of-text event is not the last of its run");

endmodule
